// ===== sv/rbs_pkg.sv =====
// Package for the retry backoff scheduler: transaction payload types, event
// command codes, register indexes and reset values of the delay registers.
// No dependencies.
`default_nettype none

package rbs_pkg;

    localparam int TIME_WIDTH  = 48;
    localparam int DELAY_WIDTH = 24;
    localparam int CNT_WIDTH   = 3;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [CNT_WIDTH-1:0] FAIL_CAP = 3'd4;

    localparam logic [DELAY_WIDTH-1:0] DELAY_FIRST_RST  = 24'd2000;
    localparam logic [DELAY_WIDTH-1:0] DELAY_SECOND_RST = 24'd5000;
    localparam logic [DELAY_WIDTH-1:0] DELAY_THIRD_RST  = 24'd10000;
    localparam logic [DELAY_WIDTH-1:0] DELAY_FOURTH_RST = 24'd30000;

    typedef enum logic [1:0] {
        REG_DELAY_FIRST  = 2'd0,
        REG_DELAY_SECOND = 2'd1,
        REG_DELAY_THIRD  = 2'd2,
        REG_DELAY_FOURTH = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        CMD_REQ_IMMEDIATE = 3'd0,
        CMD_STARTED       = 3'd1,
        CMD_SUCCEEDED     = 3'd2,
        CMD_FAILED        = 3'd3,
        CMD_CANCELLED     = 3'd4,
        CMD_QUERY         = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [2:0]            cmd;
        logic [TIME_WIDTH-1:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic                  due;
        logic                  pending;
        logic                  in_flight;
        logic                  immediate_flag;
        logic [CNT_WIDTH-1:0]  failures;
        logic [TIME_WIDTH-1:0] next_retry_time;
    } t_out_item;

endpackage

`default_nettype wire

// ===== sv/retry_backoff_scheduler.sv =====
// Retry scheduler with capped, stepped backoff and an APB delay register file.
// Depends on rbs_pkg for payload types, command codes and register constants.
//
// One event transaction is taken per clock cycle while the output register is
// free or being taken. Each accepted event updates the retry state in the same
// cycle and its result appears in the output register on the next cycle, and
// the sustained rate is one transaction per cycle when the output does not
// stall; a single add, compare and flag update feeds both registers. The input
// is ready whenever the output register is empty or is being taken. The four
// delay registers are written and read over the APB port, which has no wait
// states, and should only be changed while no event is in progress.
`default_nettype none

module retry_backoff_scheduler
    import rbs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [DELAY_WIDTH-1:0] r_delay_first;
    logic [DELAY_WIDTH-1:0] r_delay_second;
    logic [DELAY_WIDTH-1:0] r_delay_third;
    logic [DELAY_WIDTH-1:0] r_delay_fourth;

    logic                  r_imm;
    logic                  r_run;
    logic [CNT_WIDTH-1:0]  r_fail;
    logic [TIME_WIDTH-1:0] r_retry;
    logic                  n_imm;
    logic                  n_run;
    logic [CNT_WIDTH-1:0]  n_fail;
    logic [TIME_WIDTH-1:0] n_retry;

    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;

    logic                   w_accept;
    logic                   w_cfg_wr;
    t_reg_idx               w_reg_idx;
    logic [CNT_WIDTH-1:0]   w_fail_inc;
    logic [CNT_WIDTH-1:0]   w_sel_count;
    logic [DELAY_WIDTH-1:0] w_delay;
    logic [TIME_WIDTH:0]    w_sum;
    logic [TIME_WIDTH-1:0]  w_sat;

    assign pready      = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_reg_idx   = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr    = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_first  <= DELAY_FIRST_RST;
            r_delay_second <= DELAY_SECOND_RST;
            r_delay_third  <= DELAY_THIRD_RST;
            r_delay_fourth <= DELAY_FOURTH_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_DELAY_FIRST:  r_delay_first  <= pwdata[DELAY_WIDTH-1:0];
                REG_DELAY_SECOND: r_delay_second <= pwdata[DELAY_WIDTH-1:0];
                REG_DELAY_THIRD:  r_delay_third  <= pwdata[DELAY_WIDTH-1:0];
                REG_DELAY_FOURTH: r_delay_fourth <= pwdata[DELAY_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_DELAY_FIRST:  prdata = APB_DATA_W'(r_delay_first);
            REG_DELAY_SECOND: prdata = APB_DATA_W'(r_delay_second);
            REG_DELAY_THIRD:  prdata = APB_DATA_W'(r_delay_third);
            REG_DELAY_FOURTH: prdata = APB_DATA_W'(r_delay_fourth);
            default:          prdata = '0;
        endcase
    end

    // A failure looks up the delay with the raised count, a cancel with the
    // current one. Counts 0 and 1 both use the first delay.
    assign w_fail_inc  = (r_fail < FAIL_CAP) ? r_fail + 3'd1 : r_fail;
    assign w_sel_count = (i_in_data.cmd == CMD_FAILED) ? w_fail_inc : r_fail;

    always_comb begin
        case (w_sel_count)
            3'd0, 3'd1: w_delay = r_delay_first;
            3'd2:       w_delay = r_delay_second;
            3'd3:       w_delay = r_delay_third;
            default:    w_delay = r_delay_fourth;
        endcase
    end

    assign w_sum = {1'b0, i_in_data.now_time} + (TIME_WIDTH + 1)'(w_delay);
    assign w_sat = w_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : w_sum[TIME_WIDTH-1:0];

    always_comb begin
        n_imm   = r_imm;
        n_run   = r_run;
        n_fail  = r_fail;
        n_retry = r_retry;
        case (i_in_data.cmd)
            CMD_REQ_IMMEDIATE: begin
                n_imm   = 1'b1;
                n_retry = '0;
            end
            CMD_STARTED: begin
                n_imm   = 1'b0;
                n_run   = 1'b1;
                n_retry = '0;
            end
            CMD_SUCCEEDED: begin
                n_imm   = 1'b0;
                n_run   = 1'b0;
                n_fail  = '0;
                n_retry = '0;
            end
            CMD_FAILED: begin
                n_imm   = 1'b0;
                n_run   = 1'b0;
                n_fail  = w_fail_inc;
                n_retry = w_sat;
            end
            CMD_CANCELLED: begin
                n_run   = 1'b0;
                n_retry = r_imm ? '0 : w_sat;
            end
            default: ;
        endcase

        n_out_data.due             = !n_run && (n_imm ||
                                     (n_retry != '0 && i_in_data.now_time >= n_retry));
        n_out_data.pending         = n_imm || n_run || (n_retry != '0);
        n_out_data.in_flight       = n_run;
        n_out_data.immediate_flag  = n_imm;
        n_out_data.failures        = n_fail;
        n_out_data.next_retry_time = n_retry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imm       <= 1'b0;
            r_run       <= 1'b0;
            r_fail      <= '0;
            r_retry     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_imm       <= n_imm;
                r_run       <= n_run;
                r_fail      <= n_fail;
                r_retry     <= n_retry;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rbs_checker.sv =====
// Port-level checker for the retry backoff scheduler and its bind statement.
// Depends on rbs_pkg for the payload types.
`default_nettype none

module rbs_checker
    import rbs_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Result changed or dropped while stalled.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("Accepted transaction produced no result.");

    a_pending_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.pending == (o_out_data.in_flight ||
            o_out_data.immediate_flag || o_out_data.next_retry_time != '0))
        else $error("Pending flag disagrees with the reported state.");

    a_fail_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.failures <= FAIL_CAP)
        else $error("Failure count exceeds its cap.");

    a_due_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.due |-> !o_out_data.in_flight)
        else $error("Retry reported due while a probe is running.");

endmodule

bind retry_backoff_scheduler rbs_checker u_rbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
